FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the motor command deframer.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on the rising clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication check: the consequent holds in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication check: the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tmcd_pkg.sv
// Package of the motor command deframer: field widths, codes and the result type.
// No dependencies; the channel interfaces and the top level use it.
`timescale 1ns / 1ps

package tmcd_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ActionW  = 2;
  localparam int unsigned SpeedW   = 12;
  localparam int unsigned DataW    = 6;
  localparam int unsigned TagW     = 2;
  localparam int unsigned SlotN    = 4;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;

  localparam logic [7:0]      GoodFrameTags = 8'b0001_1011;
  localparam logic [TagW-1:0] TerminalTag   = 2'b11;
  localparam logic [CountW-1:0] MaxBytesReset = 4'd4;

  typedef enum logic [CmdW-1:0] {
    CMD_BYTE   = 2'd0,
    CMD_BUTTON = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [ActionW-1:0] {
    ACT_NONE   = 2'd0,
    ACT_SPEEDS = 2'd1,
    ACT_STOP   = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_BYTES = 1'd0,
    CFG_WDOG_EN   = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    action_e           action;
    logic [SpeedW-1:0] right_speed;
    logic [SpeedW-1:0] left_speed;
    logic              enabled;
  } res_t;

endpackage

FILE: hw/rtl/tmcd_if.sv
// Valid/ready channel interfaces of the motor command deframer.
// Depends on tmcd_pkg for the field widths.
`timescale 1ns / 1ps

interface tmcd_evt_if;
  logic                       valid;
  logic                       ready;
  logic [tmcd_pkg::CmdW-1:0]  cmd;
  logic [tmcd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface tmcd_res_if;
  logic                          valid;
  logic                          ready;
  logic [tmcd_pkg::ActionW-1:0]  action;
  logic [tmcd_pkg::SpeedW-1:0]   right_speed;
  logic [tmcd_pkg::SpeedW-1:0]   left_speed;
  logic                          enabled;

  modport source (output valid, output action, output right_speed,
                  output left_speed, output enabled, input ready);
  modport sink   (input valid, input action, input right_speed,
                  input left_speed, input enabled, output ready);
endinterface

FILE: hw/rtl/tagged_motor_command_deframer_unit.sv
// Top level of the motor command deframer: frame state, result register and skid stage.
// Depends on tmcd_pkg, the channel interfaces in tmcd_if.sv and assert_macros.svh.
`timescale 1ns / 1ps

// Usage:
// Each word on evt_i is one event: a received byte (cmd 0), a button toggle
// (cmd 1) or a watchdog tick (cmd 2). Every accepted word yields exactly one
// word on res_o, in order: action (none, new speeds, stop), the two 12-bit
// speeds and the enable flag after the event.
// The result is registered at the edge that accepts the event, in the output
// or the skid register. Throughput is one event per cycle while evt_i.ready is
// high; one pass updates the frame state, so events never wait on each other.
// When the receiver stalls, one further result is parked in a skid register;
// evt_i.ready drops only while that skid register is full.
// The configuration port takes max_bytes_without_end (index 0) and
// watchdog_enable (index 1) on any edge with cfg_we_i high; write it only
// while idle.
// Reset clears the slots, the tag history, the byte counter, the seen flag and
// the enable flag (the block starts disabled), restores the register defaults
// and empties both output registers.

`include "assert_macros.svh"

module tagged_motor_command_deframer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tmcd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tmcd_pkg::CfgDataW-1:0] cfg_data_i,
  tmcd_evt_if.sink                      evt_i,
  tmcd_res_if.source                    res_o
);
  import tmcd_pkg::*;

  logic [CountW-1:0] max_bytes_q;
  logic              wdog_en_q;

  logic [DataW-1:0]  slot_q [SlotN];
  logic [DataW-1:0]  slot_d [SlotN];
  logic [7:0]        hist_q, hist_d;
  logic [CountW-1:0] pend_q, pend_d;
  logic              en_q, en_d;
  logic              seen_q, seen_d;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q, res_d;

  logic evt_acc, out_acc;
  logic [TagW-1:0]   tag;
  logic [CountW:0]   cnt_inc;
  logic              clear_slots;

  assign evt_i.ready = ~skid_valid_q;
  assign evt_acc     = evt_i.valid & evt_i.ready;
  assign out_acc     = out_valid_q & res_o.ready;

  assign tag     = evt_i.rx_byte[ByteW-1 -: TagW];
  assign cnt_inc = {1'b0, pend_q} + {{CountW{1'b0}}, 1'b1};

  // Next frame state and the result of the event on the input.
  always_comb begin
    hist_d      = hist_q;
    pend_d      = pend_q;
    en_d        = en_q;
    seen_d      = seen_q;
    clear_slots = 1'b0;
    res_d       = '{action: ACT_NONE, right_speed: '0, left_speed: '0, enabled: 1'b0};
    for (int i = 0; i < SlotN; i++) begin
      slot_d[i] = slot_q[i];
    end

    case (cmd_e'(evt_i.cmd))
      CMD_BYTE: begin
        seen_d = 1'b1;
        if (en_q) begin
          slot_d[tag] = evt_i.rx_byte[DataW-1:0];
          hist_d      = {hist_q[5:0], tag};
          if (tag == TerminalTag) begin
            pend_d = '0;
            if (hist_d == GoodFrameTags) begin
              res_d.action      = ACT_SPEEDS;
              res_d.right_speed = {slot_d[0], slot_d[1]};
              res_d.left_speed  = {slot_d[2], slot_d[3]};
            end else begin
              clear_slots  = 1'b1;
              res_d.action = ACT_STOP;
            end
          end else if (cnt_inc > {1'b0, max_bytes_q}) begin
            clear_slots  = 1'b1;
            res_d.action = ACT_STOP;
            pend_d       = '0;
          end else begin
            pend_d = cnt_inc[CountW-1:0];
          end
        end
      end
      CMD_BUTTON: begin
        en_d = ~en_q;
        if (en_q) begin
          clear_slots  = 1'b1;
          res_d.action = ACT_STOP;
        end
      end
      CMD_TICK: begin
        if (wdog_en_q && !seen_q) begin
          res_d.action = ACT_STOP;
        end
        seen_d = 1'b0;
      end
      default: begin
      end
    endcase

    if (clear_slots) begin
      for (int i = 0; i < SlotN; i++) begin
        slot_d[i] = '0;
      end
    end
    res_d.enabled = en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxBytesReset;
      wdog_en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_BYTES: max_bytes_q <= cfg_data_i;
        CFG_WDOG_EN:   wdog_en_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotN; i++) begin
        slot_q[i] <= '0;
      end
      hist_q <= '0;
      pend_q <= '0;
      en_q   <= 1'b0;
      seen_q <= 1'b0;
    end else if (evt_acc) begin
      slot_q <= slot_d;
      hist_q <= hist_d;
      pend_q <= pend_d;
      en_q   <= en_d;
      seen_q <= seen_d;
    end
  end

  // Output register plus skid stage. A new result goes to the output register
  // when it is free or being drained this cycle, otherwise into the skid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_acc) begin
        out_valid_q <= evt_acc | skid_valid_q;
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end
      end else if (evt_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_acc) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (evt_acc) begin
      skid_q <= res_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.action      = out_q.action;
  assign res_o.right_speed = out_q.right_speed;
  assign res_o.left_speed  = out_q.left_speed;
  assign res_o.enabled     = out_q.enabled;

  `ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q,
               "skid register holds a word while the output register is empty")
  `ASSERT_NEXT(a_accept_fills_out, evt_acc && !out_valid_q, out_valid_q,
               "accepted word did not reach the output register")
  `ASSERT_IMPL(a_speeds_need_enable, out_valid_q && out_q.action == ACT_SPEEDS,
               out_q.enabled, "speeds issued while disabled")
  `ASSERT_IMPL(a_speeds_zero_otherwise, out_valid_q && out_q.action != ACT_SPEEDS,
               out_q.right_speed == '0 && out_q.left_speed == '0,
               "nonzero speeds on a word without new speeds")

endmodule
